// File: rtl/hfcf_pkg.sv
package hfcf_pkg;

    // fixed field widths
    localparam int MAX_CLASSES = 3;
    localparam int IDX_W       = 2;
    localparam int Q_W         = 16;
    localparam int CODE_W      = 8;
    localparam int ROW_W       = 48;
    localparam int CODES_W     = 24;
    localparam int NORM_W      = 18;
    localparam int Y_W         = 18;
    localparam int U_W         = 20;
    localparam int Z_W         = 21;
    localparam int BELIEF_W    = 17;
    localparam int PROD_W      = 36;
    localparam int CFG_IDX_W   = 8;

    localparam logic [NORM_W-1:0] NORM_MAX = 18'h3FFFF;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TRANS0 = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRANS1 = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TRANS2 = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CONF0  = 8'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CONF1  = 8'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CONF2  = 8'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PRIOR  = 8'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_CODES  = 8'd7;

    // register reset values
    localparam logic [ROW_W-1:0]   ROW0_RST  = 48'h0000_0000_FFFF;
    localparam logic [ROW_W-1:0]   ROW1_RST  = 48'h0000_FFFF_0000;
    localparam logic [ROW_W-1:0]   ROW2_RST  = 48'hFFFF_0000_0000;
    localparam logic [ROW_W-1:0]   PRIOR_RST = 48'h5555_5555_5555;
    localparam logic [CODES_W-1:0] CODES_RST = 24'h02_01_00;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MAP,
        ST_TRANS,
        ST_WEIGHT,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_WINDOW,
        ST_MEAN_START,
        ST_MEAN_WAIT,
        ST_OUT
    } state_t;

    // q0.16 entry j of a packed row
    function automatic logic [Q_W-1:0] entry16(input logic [ROW_W-1:0] w,
                                              input logic [IDX_W-1:0] j);
        return w[Q_W*j +: Q_W];
    endfunction

    // detector code of index j
    function automatic logic [CODE_W-1:0] code8(input logic [CODES_W-1:0] c,
                                               input logic [IDX_W-1:0] j);
        return c[CODE_W*j +: CODE_W];
    endfunction

endpackage

// File: rtl/hfcf_div.sv
module hfcf_div #(
    parameter int NUM_W  = 23,
    parameter int DEN_W  = 21,
    parameter int STEP_W = 5
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DEN_W-1:0]  rem_init,
    input  logic [NUM_W-1:0]  num,
    input  logic [STEP_W-1:0] steps,
    input  logic [DEN_W-1:0]  den,
    output logic              done,
    output logic [NUM_W-1:0]  quot
);

    logic [DEN_W-1:0]  rem_reg;
    logic [NUM_W-1:0]  num_reg;
    logic [NUM_W-1:0]  quot_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic              run_reg;
    logic              done_reg;

    logic [DEN_W:0]    trial;
    logic              ge;
    logic [DEN_W-1:0]  rem_next;

    // one restoring step per cycle, remainder stays below the divisor
    assign trial    = {rem_reg, num_reg[NUM_W-1]};
    assign ge       = (trial >= {1'b0, den_reg});
    assign rem_next = ge ? DEN_W'(trial - {1'b0, den_reg}) : DEN_W'(trial);

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= steps;
        end
        else if (run_reg)
        begin
            cnt_reg <= cnt_reg - STEP_W'(1);
            if (cnt_reg == STEP_W'(1))
            begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= rem_init;
            num_reg  <= num;
            den_reg  <= den;
            quot_reg <= '0;
        end
        else if (run_reg)
        begin
            rem_reg  <= rem_next;
            num_reg  <= {num_reg[NUM_W-2:0], 1'b0};
            quot_reg <= {quot_reg[NUM_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// File: rtl/hmm_forward_class_filter.sv
// hmm forward class filter
// keeps a belief over up to three classes and updates it once per detection
// input channel s_*: one detection per request; s_tready is high only while
// the block is idle, the request is taken when s_tvalid and s_tready are high
// output channel m_*: one result per detection, held in an output register
// config channel cfg_*: always ready, write only while the block is idle
// an item runs the mapping products, the transition products (once started)
// and the weighting products on the one shared 18x18 multiplier, then one
// division per class (skipped when the sum is zero) and one mean division on
// the serial divider, plus the request, window and output-load steps
// the next item is taken as soon as the result sits in the output register,
// a stalled receiver holds the result there and the sequencer waits in its
// last step until the register is free
// reset clears the belief, the window count, sum and pointer and restores
// the configuration registers; the window entries are not cleared, an entry
// is only read back after it has been written
module hmm_forward_class_filter #(
    parameter int NUM_CLASSES  = 3,
    parameter int WINDOW_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // detected_code[7:0], confidence0[23:8], confidence1[39:24], confidence2[55:40]
    input  logic [55:0] s_tdata,
    // single_confidence
    input  logic        s_tuser,
    input  logic        s_tvalid,
    output logic        s_tready,
    // likely_code[7:0], likely_index[9:8], mean_normalizer[27:10], zero[31:28]
    output logic [31:0] m_tdata,
    // unknown_code
    output logic        m_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [47:0] cfg_data
);

    localparam int CNT_W     = $clog2(WINDOW_DEPTH + 1);
    localparam int PTR_W     = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int SUM_W     = hfcf_pkg::NORM_W + CNT_W;
    localparam int STEP_W    = $clog2(SUM_W + 1);
    localparam int SHARE_DIV = NUM_CLASSES - 1;
    localparam int Q_W       = hfcf_pkg::Q_W;
    localparam int IDX_W     = hfcf_pkg::IDX_W;
    localparam int MAXC      = hfcf_pkg::MAX_CLASSES;

    // configuration registers
    logic [hfcf_pkg::ROW_W-1:0]   trans_reg [MAXC];
    logic [hfcf_pkg::ROW_W-1:0]   conf_reg  [MAXC];
    logic [hfcf_pkg::ROW_W-1:0]   prior_reg;
    logic [hfcf_pkg::CODES_W-1:0] codes_reg;

    // sequencer and datapath registers
    hfcf_pkg::state_t state_reg, state_next;
    logic [IDX_W-1:0]             i_reg;
    logic [IDX_W-1:0]             j_reg;
    logic [Q_W-1:0]               x_reg      [MAXC];
    logic [hfcf_pkg::Y_W-1:0]     y_reg      [MAXC];
    logic [hfcf_pkg::Y_W-1:0]     w_reg      [MAXC];
    logic [hfcf_pkg::U_W-1:0]     u_reg      [MAXC];
    logic [hfcf_pkg::BELIEF_W-1:0] belief_reg [MAXC];
    logic [hfcf_pkg::PROD_W-1:0]  acc_reg;
    logic [hfcf_pkg::Z_W-1:0]     z_reg;
    logic                         q16_reg;
    logic                         started_reg;
    logic                         unknown_reg;
    logic [hfcf_pkg::NORM_W-1:0]  mean_reg;
    logic [PTR_W-1:0]             ptr_reg;
    logic [CNT_W-1:0]             cnt_reg;
    logic [SUM_W-1:0]             sum_reg;
    logic [hfcf_pkg::NORM_W-1:0]  rd_reg;
    logic [hfcf_pkg::NORM_W-1:0]  normalizer_window [WINDOW_DEPTH];
    logic                         m_tvalid_reg;
    logic [31:0]                  m_tdata_reg;
    logic                         m_tuser_reg;

    // combinational signals
    logic [Q_W-1:0]               conf_in [MAXC];
    logic [IDX_W-1:0]             idx_in;
    logic                         unk_in;
    logic [Q_W:0]                 share;
    logic [Q_W-1:0]               share_sat;
    logic [Q_W-1:0]               x_in    [MAXC];
    logic [hfcf_pkg::Y_W-1:0]     mul_a;
    logic [hfcf_pkg::Y_W-1:0]     mul_b;
    logic [hfcf_pkg::PROD_W-1:0]  prod;
    logic [hfcf_pkg::PROD_W-1:0]  acc_sum;
    logic [hfcf_pkg::U_W-1:0]     u_new;
    logic                         last_i;
    logic                         last_j;
    logic                         accept;
    logic                         out_free;
    logic                         z_zero;
    logic [hfcf_pkg::NORM_W-1:0]  zs;
    logic [hfcf_pkg::BELIEF_W-1:0] best;
    logic [IDX_W-1:0]             arg;
    logic                         div_start;
    logic [hfcf_pkg::Z_W-1:0]     div_rem_init;
    logic [SUM_W-1:0]             div_num;
    logic [STEP_W-1:0]            div_steps;
    logic [hfcf_pkg::Z_W-1:0]     div_den;
    logic                         div_done;
    logic [SUM_W-1:0]             div_quot;

    assign cfg_ready = 1'b1;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trans_reg[0] <= hfcf_pkg::ROW0_RST;
            trans_reg[1] <= hfcf_pkg::ROW1_RST;
            trans_reg[2] <= hfcf_pkg::ROW2_RST;
            conf_reg[0]  <= hfcf_pkg::ROW0_RST;
            conf_reg[1]  <= hfcf_pkg::ROW1_RST;
            conf_reg[2]  <= hfcf_pkg::ROW2_RST;
            prior_reg    <= hfcf_pkg::PRIOR_RST;
            codes_reg    <= hfcf_pkg::CODES_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                hfcf_pkg::CFG_TRANS0: trans_reg[0] <= cfg_data;
                hfcf_pkg::CFG_TRANS1: trans_reg[1] <= cfg_data;
                hfcf_pkg::CFG_TRANS2: trans_reg[2] <= cfg_data;
                hfcf_pkg::CFG_CONF0:  conf_reg[0]  <= cfg_data;
                hfcf_pkg::CFG_CONF1:  conf_reg[1]  <= cfg_data;
                hfcf_pkg::CFG_CONF2:  conf_reg[2]  <= cfg_data;
                hfcf_pkg::CFG_PRIOR:  prior_reg    <= cfg_data;
                hfcf_pkg::CFG_CODES:  codes_reg    <= cfg_data[hfcf_pkg::CODES_W-1:0];
                default: ;
            endcase
        end
    end

    // request decode: code lookup and observation vector
    assign conf_in[0] = s_tdata[23:8];
    assign conf_in[1] = s_tdata[39:24];
    assign conf_in[2] = s_tdata[55:40];
    assign share      = (Q_W+1)'((17'h10000 - {1'b0, conf_in[0]}) / SHARE_DIV);
    assign share_sat  = share[Q_W] ? {Q_W{1'b1}} : share[Q_W-1:0];

    always_comb
    begin
        idx_in = '0;
        unk_in = 1'b1;
        // scan downward so the first match wins
        for (int k = NUM_CLASSES - 1; k >= 0; k--)
        begin
            if (hfcf_pkg::code8(codes_reg, IDX_W'(k)) == s_tdata[7:0])
            begin
                idx_in = IDX_W'(k);
                unk_in = 1'b0;
            end
        end
        for (int k = 0; k < MAXC; k++)
        begin
            if (s_tuser)
                x_in[k] = (IDX_W'(k) == idx_in) ? conf_in[0] : share_sat;
            else
                x_in[k] = conf_in[k];
        end
    end

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            hfcf_pkg::ST_MAP:
            begin
                mul_a = hfcf_pkg::Y_W'(hfcf_pkg::entry16(conf_reg[i_reg], j_reg));
                mul_b = hfcf_pkg::Y_W'(x_reg[j_reg]);
            end
            hfcf_pkg::ST_TRANS:
            begin
                mul_a = hfcf_pkg::Y_W'(hfcf_pkg::entry16(trans_reg[i_reg], j_reg));
                mul_b = hfcf_pkg::Y_W'(belief_reg[j_reg]);
            end
            hfcf_pkg::ST_WEIGHT:
            begin
                mul_a = y_reg[i_reg];
                mul_b = started_reg ? w_reg[i_reg]
                      : hfcf_pkg::Y_W'(hfcf_pkg::entry16(prior_reg, i_reg));
            end
            default: ;
        endcase
    end

    assign prod    = hfcf_pkg::PROD_W'(mul_a) * hfcf_pkg::PROD_W'(mul_b);
    assign acc_sum = ((j_reg == '0) ? '0 : acc_reg) + prod;
    assign u_new   = prod[Q_W +: hfcf_pkg::U_W];
    assign last_i  = (i_reg == IDX_W'(NUM_CLASSES - 1));
    assign last_j  = (j_reg == IDX_W'(NUM_CLASSES - 1));
    assign z_zero  = (z_reg == '0);
    assign zs      = (z_reg > hfcf_pkg::Z_W'(hfcf_pkg::NORM_MAX)) ? hfcf_pkg::NORM_MAX
                   : z_reg[hfcf_pkg::NORM_W-1:0];
    assign out_free = !m_tvalid_reg || m_tready;

    // argmax, first strictly largest entry
    always_comb
    begin
        best = '0;
        arg  = '0;
        for (int k = 0; k < NUM_CLASSES; k++)
        begin
            if (belief_reg[k] > best)
            begin
                best = belief_reg[k];
                arg  = IDX_W'(k);
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            hfcf_pkg::ST_IDLE:
                if (s_tvalid)
                    state_next = hfcf_pkg::ST_MAP;
            hfcf_pkg::ST_MAP:
                if (last_i && last_j)
                    state_next = started_reg ? hfcf_pkg::ST_TRANS : hfcf_pkg::ST_WEIGHT;
            hfcf_pkg::ST_TRANS:
                if (last_i && last_j)
                    state_next = hfcf_pkg::ST_WEIGHT;
            hfcf_pkg::ST_WEIGHT:
                if (last_i)
                    state_next = hfcf_pkg::ST_DIV_START;
            hfcf_pkg::ST_DIV_START:
                if (!z_zero)
                    state_next = hfcf_pkg::ST_DIV_WAIT;
                else if (last_i)
                    state_next = hfcf_pkg::ST_WINDOW;
            hfcf_pkg::ST_DIV_WAIT:
                if (div_done)
                    state_next = last_i ? hfcf_pkg::ST_WINDOW : hfcf_pkg::ST_DIV_START;
            hfcf_pkg::ST_WINDOW:
                state_next = hfcf_pkg::ST_MEAN_START;
            hfcf_pkg::ST_MEAN_START:
                state_next = hfcf_pkg::ST_MEAN_WAIT;
            hfcf_pkg::ST_MEAN_WAIT:
                if (div_done)
                    state_next = hfcf_pkg::ST_OUT;
            hfcf_pkg::ST_OUT:
                if (out_free)
                    state_next = hfcf_pkg::ST_IDLE;
            default:
                state_next = hfcf_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        s_tready     = 1'b0;
        div_start    = 1'b0;
        div_rem_init = '0;
        div_num      = '0;
        div_steps    = STEP_W'(Q_W);
        div_den      = z_reg;
        unique case (state_reg)
            hfcf_pkg::ST_IDLE:
                s_tready = 1'b1;
            hfcf_pkg::ST_DIV_START:
            begin
                // top quotient bit by compare, the other 16 on the divider
                div_start    = !z_zero;
                div_rem_init = (hfcf_pkg::Z_W'(u_reg[i_reg]) >= z_reg)
                             ? hfcf_pkg::Z_W'(u_reg[i_reg]) - z_reg
                             : hfcf_pkg::Z_W'(u_reg[i_reg]);
            end
            hfcf_pkg::ST_MEAN_START:
            begin
                div_start = 1'b1;
                div_num   = sum_reg;
                div_steps = STEP_W'(SUM_W);
                div_den   = hfcf_pkg::Z_W'(cnt_reg);
            end
            default: ;
        endcase
    end

    assign accept = s_tvalid && s_tready;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= hfcf_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // belief and window state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            belief_reg[0] <= '0;
            belief_reg[1] <= '0;
            belief_reg[2] <= '0;
            started_reg   <= 1'b0;
            ptr_reg       <= '0;
            cnt_reg       <= '0;
            sum_reg       <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
        end
        else
        begin
            unique case (state_reg) inside
                hfcf_pkg::ST_IDLE:
                begin
                    i_reg <= '0;
                    j_reg <= '0;
                end
                hfcf_pkg::ST_MAP, hfcf_pkg::ST_TRANS:
                begin
                    if (last_j)
                    begin
                        j_reg <= '0;
                        i_reg <= last_i ? '0 : i_reg + IDX_W'(1);
                    end
                    else
                    begin
                        j_reg <= j_reg + IDX_W'(1);
                    end
                end
                hfcf_pkg::ST_WEIGHT:
                    i_reg <= last_i ? '0 : i_reg + IDX_W'(1);
                hfcf_pkg::ST_DIV_START:
                begin
                    if (z_zero)
                    begin
                        belief_reg[i_reg] <= '0;
                        i_reg <= last_i ? '0 : i_reg + IDX_W'(1);
                    end
                end
                hfcf_pkg::ST_DIV_WAIT:
                begin
                    if (div_done)
                    begin
                        belief_reg[i_reg] <= {q16_reg, div_quot[Q_W-1:0]};
                        i_reg <= last_i ? '0 : i_reg + IDX_W'(1);
                    end
                end
                hfcf_pkg::ST_WINDOW:
                begin
                    started_reg <= 1'b1;
                    ptr_reg <= (ptr_reg == PTR_W'(WINDOW_DEPTH - 1)) ? '0
                             : ptr_reg + PTR_W'(1);
                    if (cnt_reg >= CNT_W'(WINDOW_DEPTH))
                        sum_reg <= sum_reg - SUM_W'(rd_reg) + SUM_W'(zs);
                    else
                    begin
                        cnt_reg <= cnt_reg + CNT_W'(1);
                        sum_reg <= sum_reg + SUM_W'(zs);
                    end
                end
                default: ;
            endcase
        end
    end

    // arithmetic payload
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            hfcf_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    x_reg[0]    <= x_in[0];
                    x_reg[1]    <= x_in[1];
                    x_reg[2]    <= x_in[2];
                    unknown_reg <= unk_in;
                end
            end
            hfcf_pkg::ST_MAP:
            begin
                acc_reg <= acc_sum;
                if (last_j)
                    y_reg[i_reg] <= acc_sum[Q_W +: hfcf_pkg::Y_W];
            end
            hfcf_pkg::ST_TRANS:
            begin
                acc_reg <= acc_sum;
                if (last_j)
                    w_reg[i_reg] <= acc_sum[Q_W +: hfcf_pkg::Y_W];
            end
            hfcf_pkg::ST_WEIGHT:
            begin
                u_reg[i_reg] <= u_new;
                z_reg <= ((i_reg == '0) ? '0 : z_reg) + hfcf_pkg::Z_W'(u_new);
            end
            hfcf_pkg::ST_DIV_START:
                q16_reg <= (hfcf_pkg::Z_W'(u_reg[i_reg]) >= z_reg);
            hfcf_pkg::ST_MEAN_WAIT:
                if (div_done)
                    mean_reg <= div_quot[hfcf_pkg::NORM_W-1:0];
            default: ;
        endcase
    end

    // normalizer window memory with registered read
    always_ff @(posedge clk)
    begin
        if (state_reg == hfcf_pkg::ST_WINDOW)
            normalizer_window[ptr_reg] <= zs;
        rd_reg <= normalizer_window[ptr_reg];
    end

    // shared serial divider
    hfcf_div #(
        .NUM_W  (SUM_W),
        .DEN_W  (hfcf_pkg::Z_W),
        .STEP_W (STEP_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .rem_init (div_rem_init),
        .num      (div_num),
        .steps    (div_steps),
        .den      (div_den),
        .done     (div_done),
        .quot     (div_quot)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (state_reg == hfcf_pkg::ST_OUT && out_free)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == hfcf_pkg::ST_OUT && out_free)
        begin
            m_tdata_reg <= {4'b0, mean_reg, arg, hfcf_pkg::code8(codes_reg, arg)};
            m_tuser_reg <= unknown_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// File: rtl/hfcf_checker.sv
module hfcf_checker #(
    parameter int NUM_CLASSES = 3
) (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tuser
);

    // a stalled result holds
    property p_out_hold;
        @(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser));
    endproperty
    a_out_hold: assert property (p_out_hold) else $error("stalled result changed");

    // one request at a time: not ready right after a request
    property p_busy_after_req;
        @(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready;
    endproperty
    a_busy_after_req: assert property (p_busy_after_req) else $error("ready after request");

    // likely index stays within the class count
    property p_index_range;
        @(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[9:8] < 2'(NUM_CLASSES));
    endproperty
    a_index_range: assert property (p_index_range) else $error("likely index out of range");

    // no result appears in the cycle after a request
    property p_no_early_result;
        @(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && !m_tvalid) |=> !m_tvalid;
    endproperty
    a_no_early_result: assert property (p_no_early_result) else $error("result too early");

endmodule

bind hmm_forward_class_filter hfcf_checker #(.NUM_CLASSES(NUM_CLASSES)) u_hfcf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
